// ===== rtl/core/hmrs_pkg.sv =====
package hmrs_pkg;

   // Width of the height field on the request channel.
   localparam int HEIGHT_IN_W = 16;

   // Width of the reported area; larger products saturate to the all-ones value.
   localparam int AREA_W = 26;
   localparam logic [AREA_W-1:0] AREA_MAX = '1;

endpackage

// ===== rtl/core/hmrs_stack.sv =====
module hmrs_stack #(
   parameter int DEPTH = 1024,
   parameter int DW    = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/histogram_max_rectangle_stack_unit.sv =====
// Largest rectangle in a histogram, computed on the fly with a monotonic stack.
// Request channel (req_valid/req_ready): one bar height per transaction;
// req_last marks the final bar of a run. Response channel (rsp_valid/rsp_ready):
// one transaction per run, carrying the largest area and an overflow flag.
// A bar that pops nothing is accepted, then compared and pushed or merged.
// Each stack entry popped then goes through a registered stack memory read,
// one multiply of height by width, then a saturate-and-compare into the best area.
// Each bar is pushed and popped at most once. The final bar is followed by an
// internal zero-height bar that drains the stack, after which the result is
// loaded into the output register and the run state clears. An overflowing
// final bar skips its own compare and goes straight to the drain.
// New bars are taken while a result waits for rsp_ready; the next result is
// held back until the earlier one is taken.
// More than MAX_BARS bars in a run sets overflow and forces the area to zero.
// Synchronous reset empties the stack and clears all run state; the stack
// memory itself is not cleared, since reads are gated by the entry count.
module histogram_max_rectangle_stack_unit #(
   parameter int MAX_BARS    = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hmrs_pkg::HEIGHT_IN_W-1:0] req_height,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [hmrs_pkg::AREA_W-1:0]    rsp_max_area,
   output logic                           rsp_overflow
);

   import hmrs_pkg::*;

   localparam int HW    = (HEIGHT_BITS < HEIGHT_IN_W) ? HEIGHT_BITS : HEIGHT_IN_W;
   localparam int IDX_W = $clog2(MAX_BARS + 2);
   localparam int CNT_W = $clog2(MAX_BARS + 1);
   localparam int AW    = $clog2(MAX_BARS);
   localparam int DW    = IDX_W + HW;
   localparam int PW    = HW + IDX_W;
   localparam int CW    = (PW > AREA_W) ? PW : AREA_W;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BARS);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BARS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_RD,
      ST_ACC,
      ST_FIN
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   bar_ff;
   logic [IDX_W-1:0]   base_ff;
   logic [HW-1:0]      top_h_ff;
   logic [IDX_W-1:0]   cur_i_ff;
   logic [HW-1:0]      cur_h_ff;
   logic [HW-1:0]      pop_h_ff;
   logic [PW-1:0]      prod_ff;
   logic [AREA_W-1:0]  best_ff;
   logic               ovf_ff;
   logic               last_ff;
   logic               drain_ff;
   logic               rsp_valid_ff;
   logic [AREA_W-1:0]  rsp_area_ff;
   logic               rsp_ovf_ff;

   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W-1:0]   cnt_m2;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DW-1:0]      wr_data;
   logic [DW-1:0]      rd_data;
   logic [IDX_W-1:0]   rd_idx;
   logic [HW-1:0]      rd_h;
   logic [IDX_W-1:0]   left_idx;
   logic [IDX_W-1:0]   span;
   logic [PW-1:0]      prod_w;
   logic [AREA_W-1:0]  area_sat;
   logic               do_pop;

   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign cnt_m2 = cnt_ff - CNT_W'(2);
   assign rd_idx = rd_data[DW-1:HW];
   assign rd_h   = rd_data[HW-1:0];

   // The top height is mirrored in a register; the memory holds the whole stack.
   assign do_pop = (cnt_ff != '0) && (cur_h_ff < top_h_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = {cur_i_ff, cur_h_ff};
      if (state_ff == ST_CMP && !do_pop) begin
         if (cnt_ff != '0) begin
            if (cur_h_ff == top_h_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_m1[AW-1:0];
            end else if (cnt_ff < MAX_CNT) begin
               wr_en = 1'b1;
            end
         end else if (cur_h_ff != '0) begin
            wr_en = 1'b1;
         end
      end
   end

   hmrs_stack #(
      .DEPTH (MAX_BARS),
      .DW    (DW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   // Left edge of a popped bar is the entry below it, or the base when none.
   assign left_idx = (cnt_ff >= CNT_W'(2)) ? rd_idx : base_ff;
   assign span     = cur_i_ff - left_idx - IDX_W'(1);
   assign prod_w   = PW'(pop_h_ff) * PW'(span);
   assign area_sat = (CW'(prod_ff) > CW'(AREA_MAX)) ? AREA_MAX : AREA_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bar_ff       <= '0;
         base_ff      <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (bar_ff >= MAX_IDX) begin
                     ovf_ff <= 1'b1;
                     if (req_last) begin
                        cur_i_ff <= bar_ff + IDX_W'(1);
                        cur_h_ff <= '0;
                        drain_ff <= 1'b1;
                        state_ff <= ST_CMP;
                     end
                  end else begin
                     bar_ff   <= bar_ff + IDX_W'(1);
                     cur_i_ff <= bar_ff + IDX_W'(1);
                     cur_h_ff <= req_height[HW-1:0];
                     last_ff  <= req_last;
                     drain_ff <= 1'b0;
                     state_ff <= ST_CMP;
                  end
               end
            end
            ST_CMP: begin
               if (do_pop) begin
                  pop_h_ff <= top_h_ff;
                  state_ff <= ST_RD;
               end else begin
                  // An equal bar only rewrites the top entry's index in memory.
                  if (cnt_ff != '0) begin
                     if (cur_h_ff != top_h_ff && cnt_ff < MAX_CNT) begin
                        top_h_ff <= cur_h_ff;
                        cnt_ff   <= cnt_ff + CNT_W'(1);
                     end
                  end else if (cur_h_ff == '0) begin
                     base_ff <= cur_i_ff;
                  end else begin
                     top_h_ff <= cur_h_ff;
                     cnt_ff   <= CNT_W'(1);
                  end
                  if (drain_ff) begin
                     state_ff <= ST_FIN;
                  end else if (last_ff) begin
                     cur_i_ff <= bar_ff + IDX_W'(1);
                     cur_h_ff <= '0;
                     drain_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_RD: begin
               prod_ff  <= prod_w;
               top_h_ff <= rd_h;
               cnt_ff   <= cnt_m1;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (area_sat > best_ff) begin
                  best_ff <= area_sat;
               end
               state_ff <= ST_CMP;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_area_ff  <= ovf_ff ? '0 : best_ff;
                  rsp_ovf_ff   <= ovf_ff;
                  cnt_ff       <= '0;
                  bar_ff       <= '0;
                  base_ff      <= '0;
                  best_ff      <= '0;
                  ovf_ff       <= 1'b0;
                  last_ff      <= 1'b0;
                  drain_ff     <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;
   assign rsp_overflow = rsp_ovf_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("stack count exceeds its depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> cnt_ff != '0)
      else $error("pop from an empty stack");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish step");

   a_fin_empties: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> cnt_ff == '0)
      else $error("stack not drained at end of run");
`endif

endmodule

// ===== test/tb_histogram_max_rectangle_stack_unit.sv =====
module tb_histogram_max_rectangle_stack_unit;
   import hmrs_pkg::*;

   localparam int MAX_BARS    = 1024;
   localparam int POS_W       = 11;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BARS = 575;

   typedef enum int {
      SHAPE_LOW,
      SHAPE_FULL,
      SHAPE_HIGH,
      SHAPE_RAMP,
      SHAPE_MAX
   } bar_shape_type;

   typedef enum int {
      READY_ALWAYS,
      READY_SPARSE,
      READY_COIN
   } ready_pattern_type;

   typedef struct {
      logic [HEIGHT_IN_W-1:0] height;
      logic                   last;
      bit                     drain_first;
   } bar_item_type;

   typedef struct {
      logic [AREA_W-1:0] area;
      logic              overflow;
   } area_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [HEIGHT_IN_W-1:0] req_height = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [AREA_W-1:0]      rsp_max_area;
   logic                   rsp_overflow;

   histogram_max_rectangle_stack_unit #(
      .MAX_BARS   (MAX_BARS),
      .HEIGHT_BITS(HEIGHT_IN_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_height  (req_height),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_max_area(rsp_max_area),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   bar_item_type    bar_queue[$];
   area_result_type area_due[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   logic            req_hs = 1'b0;

   // Shadow of the monotonic stack and the run state.
   logic [POS_W-1:0]       mono_pos[MAX_BARS];
   logic [HEIGHT_IN_W-1:0] mono_height[MAX_BARS];
   int                     mono_depth;
   logic [POS_W-1:0]       floor_pos;
   logic [POS_W-1:0]       bars_seen;
   logic [AREA_W-1:0]      best_area;
   logic                   run_overflow;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic clear_run();
      mono_depth   = 0;
      floor_pos    = '0;
      bars_seen    = '0;
      best_area    = '0;
      run_overflow = 1'b0;
   endtask

   task automatic score_span(input logic [HEIGHT_IN_W-1:0] h, input logic [POS_W-1:0] right,
                             input logic [POS_W-1:0] left);
      logic [POS_W-1:0]             span;
      logic [HEIGHT_IN_W+POS_W-1:0] product;
      span    = right - left - 1'b1;
      product = h * span;
      if (product > AREA_MAX) begin
         product = AREA_MAX;
      end
      if (product[AREA_W-1:0] > best_area) begin
         best_area = product[AREA_W-1:0];
      end
   endtask

   task automatic fold_bar(input logic [POS_W-1:0] pos, input logic [HEIGHT_IN_W-1:0] h);
      logic [HEIGHT_IN_W-1:0] top_h;
      logic [POS_W-1:0]       left;
      while (mono_depth > 0 && h < mono_height[mono_depth-1]) begin
         top_h = mono_height[mono_depth-1];
         mono_depth--;
         left = (mono_depth > 0) ? mono_pos[mono_depth-1] : floor_pos;
         score_span(top_h, pos, left);
      end
      if (mono_depth > 0) begin
         if (h == mono_height[mono_depth-1]) begin
            mono_pos[mono_depth-1] = pos;
         end else if (mono_depth < MAX_BARS) begin
            mono_pos[mono_depth]    = pos;
            mono_height[mono_depth] = h;
            mono_depth++;
         end
      end else if (h == '0) begin
         // A zero bar on an empty stack just moves the left boundary.
         floor_pos = pos;
      end else begin
         mono_pos[0]    = pos;
         mono_height[0] = h;
         mono_depth     = 1;
      end
   endtask

   task automatic predict_bar(input logic [HEIGHT_IN_W-1:0] h, input logic last);
      area_result_type due;
      if (bars_seen >= MAX_BARS) begin
         run_overflow = 1'b1;
      end else begin
         bars_seen = bars_seen + 1'b1;
         fold_bar(bars_seen, h);
      end
      if (last) begin
         // The trailing zero bar drains whatever is left on the stack.
         fold_bar(bars_seen + 1'b1, '0);
         due.area     = run_overflow ? '0 : best_area;
         due.overflow = run_overflow;
         area_due.insert(area_due.size(), due);
         clear_run();
      end
   endtask

   task automatic push_bar(input logic [HEIGHT_IN_W-1:0] h, input logic last,
                           input bit drain_first);
      bar_item_type item;
      item.height      = h;
      item.last        = last;
      item.drain_first = drain_first;
      bar_queue.insert(bar_queue.size(), item);
   endtask

   function automatic logic [HEIGHT_IN_W-1:0] pick_height(input bar_shape_type shape,
                                                          input int k);
      logic [HEIGHT_IN_W-1:0] h;
      case (shape)
         SHAPE_LOW:  h = HEIGHT_IN_W'($urandom_range(0, 3));
         SHAPE_FULL: h = HEIGHT_IN_W'($urandom_range(0, 65535));
         SHAPE_HIGH: h = HEIGHT_IN_W'(32'hFFFF - $urandom_range(0, 7));
         SHAPE_RAMP: h = HEIGHT_IN_W'(k * 37 + $urandom_range(0, 5));
         default:    h = '1;
      endcase
      return h;
   endfunction

   task automatic queue_run(input int count, input bar_shape_type shape, input bit drain_first);
      for (int k = 0; k < count; k++) begin
         push_bar(pick_height(shape, k), k == count - 1, drain_first && k == 0);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : drive_bars
      bar_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_hs) begin
         // Hold the current transaction until it is taken.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (bar_queue.size() > 0 &&
                   !(bar_queue[0].drain_first && area_due.size() > 0)) begin
         item = bar_queue.pop_front();
         req_valid  <= 1'b1;
         req_height <= item.height;
         req_last   <= item.last;
         if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 10);
            gap_left   = $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: the stall pattern switches at random between always ready, sparse and coin-flip.
   ready_pattern_type ready_mode = READY_ALWAYS;
   int                rx_tick = 0;

   always @(negedge clock) begin : drive_ready
      rx_tick++;
      if (rx_tick % 256 == 0) begin
         ready_mode = ready_pattern_type'($urandom_range(0, 2));
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_SPARSE: rsp_ready <= (rx_tick % 4 == 0);
         default:      rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin : monitor
      area_result_type due;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_bar(req_height, req_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (area_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result area=%0d overflow=%0b",
                                         rsp_max_area, rsp_overflow));
            end else begin
               due = area_due.pop_front();
               if (rsp_max_area !== due.area) begin
                  report_mismatch($sformatf("max_area got %0d want %0d",
                                            rsp_max_area, due.area));
               end
               if (rsp_overflow !== due.overflow) begin
                  report_mismatch($sformatf("overflow got %0b want %0b",
                                            rsp_overflow, due.overflow));
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d bars pending and %0d results due",
                  bar_queue.size(), area_due.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int            random_bars;
      int            run_len;
      int            pick;
      bar_shape_type shape;
      reset = 1'b1;
      clear_run();

      // Single zero bar: the base boundary moves and the area stays zero.
      push_bar(16'd0, 1'b1, 1'b0);
      // Single bar at full height.
      push_bar(16'hFFFF, 1'b1, 1'b0);
      // Equal heights merge into one stack entry.
      push_bar(16'd3, 1'b0, 1'b0); push_bar(16'd3, 1'b0, 1'b0); push_bar(16'd3, 1'b1, 1'b0);
      // Strictly increasing, drained only by the trailing zero.
      push_bar(16'd1, 1'b0, 1'b0); push_bar(16'd2, 1'b0, 1'b0); push_bar(16'd3, 1'b0, 1'b0);
      push_bar(16'd4, 1'b0, 1'b0); push_bar(16'd5, 1'b1, 1'b0);
      // Strictly decreasing, popping on every bar after the first.
      push_bar(16'd3, 1'b0, 1'b0); push_bar(16'd2, 1'b0, 1'b0); push_bar(16'd1, 1'b1, 1'b0);
      // Zeros between bars reset the base boundary more than once.
      push_bar(16'd0, 1'b0, 1'b0); push_bar(16'd0, 1'b0, 1'b0); push_bar(16'd2, 1'b0, 1'b0);
      push_bar(16'd0, 1'b0, 1'b0); push_bar(16'd2, 1'b0, 1'b0); push_bar(16'd2, 1'b1, 1'b0);
      // Mixed profile with pops that reach past several entries.
      push_bar(16'd2, 1'b0, 1'b0); push_bar(16'd1, 1'b0, 1'b0); push_bar(16'd5, 1'b0, 1'b0);
      push_bar(16'd6, 1'b0, 1'b0); push_bar(16'd2, 1'b0, 1'b0); push_bar(16'd3, 1'b1, 1'b0);

      random_bars = 0;
      while (random_bars < RANDOM_BARS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            run_len = $urandom_range(1, 12);
         end else if (pick < 19) begin
            run_len = $urandom_range(13, 40);
         end else begin
            run_len = $urandom_range(41, 120);
         end
         shape = bar_shape_type'($urandom_range(0, 4));
         queue_run(run_len, shape, random_bars == 0 || $urandom_range(0, 7) == 0);
         random_bars += run_len;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bar_queue.size() > 0 || req_valid || area_due.size() > 0) begin
         @(negedge clock);
      end
      repeat (50) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
